>>> rtl/reav_pkg.sv
// Shared widths, codes, reset values and helpers of the accelerated rotary value block.
`default_nettype none

package reav_pkg;

    // Default channel count
    localparam int CHANNELS_DEF = 2;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int CNT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 24;
    localparam int CPD_W      = 8;
    localparam int PER_W      = 10;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 7;
    localparam int STEP_W     = CNT_W + GAIN_W;
    localparam int PER30_W    = PER_W + 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_POLL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

    // Register reset values
    localparam logic [VAL_W-1:0] VALUE_MIN_RST = 24'd0;
    localparam logic [VAL_W-1:0] VALUE_MAX_RST = 24'd100;
    localparam logic [CPD_W-1:0] CPD_RST       = 8'd4;
    localparam logic [PER_W-1:0] PERIOD_RST    = 10'd10;
    localparam logic [TMO_W-1:0] TIMEOUT_RST   = 16'd500;

    // Speed gain thresholds in detents
    localparam logic [CNT_W-1:0] SLOW_DETENTS = 16'd5;
    localparam logic [CNT_W-1:0] FAST_DETENTS = 16'd10;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Thirty poll periods, the active time after which the duration gain kicks in
    function automatic logic [PER30_W-1:0] period_x30(input logic [PER_W-1:0] p);
        logic [PER30_W-1:0] e;
        e = PER30_W'(p);
        return (e << 5) - (e << 1);
    endfunction

    // Combined speed and duration gain
    function automatic logic [GAIN_W-1:0] gain_of(input logic reversed,
                                                  input logic [CNT_W-1:0] det,
                                                  input logic dur10);
        logic [GAIN_W-1:0] g;
        if (reversed) begin
            g = 7'd1;
        end else if (det < SLOW_DETENTS) begin
            g = dur10 ? 7'd10 : 7'd1;
        end else if (det < FAST_DETENTS) begin
            g = dur10 ? 7'd20 : 7'd2;
        end else begin
            g = dur10 ? 7'd100 : 7'd10;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rotary_encoder_accelerated_value.sv
// Top level: per-channel encoder state, sequencer and saturating value update.
// Start, stop, still and ignored items are done in the cycle after acceptance, with no result.
// A moving poll goes through the evaluate state, the 16-step shared divider, the gain state
// and the update state, which waits while a held result still fills the result register.
// A new item is taken only when the last one is through, so a held result also holds the input.
// Reset clears channel state, restores registers.
`default_nettype none

module rotary_encoder_accelerated_value #(
    parameter int CHANNELS = reav_pkg::CHANNELS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [reav_pkg::REQ_W-1:0]       s_req_type,
    input  wire logic                             s_channel,
    input  wire logic [reav_pkg::CNT_W-1:0]       s_counter,
    input  wire logic [reav_pkg::TIME_W-1:0]      s_now_ms,
    // Result items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_out_channel,
    output logic [reav_pkg::VAL_W-1:0]            m_value,
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [reav_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [reav_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = reav_pkg::CNT_W;
    localparam int TIME_W  = reav_pkg::TIME_W;
    localparam int VAL_W   = reav_pkg::VAL_W;
    localparam int CPD_W   = reav_pkg::CPD_W;
    localparam int STEP_W  = reav_pkg::STEP_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_GAIN  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0] state_reg;

    // Configuration registers
    logic [VAL_W-1:0]           value_min_reg;
    logic [VAL_W-1:0]           value_max_reg;
    logic [CPD_W-1:0]           cpd_reg;
    logic [reav_pkg::PER_W-1:0] period_reg;
    logic [reav_pkg::TMO_W-1:0] timeout_reg;

    // Per-channel state
    logic              enabled_reg   [CHANNELS];
    logic [CNT_W-1:0]  last_count_reg[CHANNELS];
    logic              turning_reg   [CHANNELS];
    logic              last_dir_reg  [CHANNELS];
    logic [CPD_W-1:0]  residue_reg   [CHANNELS];
    logic [TIME_W-1:0] active_reg    [CHANNELS];
    logic [TIME_W-1:0] deadline_reg  [CHANNELS];
    logic [VAL_W-1:0]  value_reg     [CHANNELS];

    // Item under work
    logic [reav_pkg::REQ_W-1:0] req_reg;
    logic [CH_W-1:0]            ch_reg;
    logic                       ch_bit_reg;
    logic                       ch_ok_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [TIME_W-1:0]          now_reg;
    logic                       fwd_reg;
    logic                       reversed_reg;
    logic [TIME_W-1:0]          act_sum_reg;
    logic [STEP_W-1:0]          step_reg;

    // Result register
    logic             m_valid_reg;
    logic             m_channel_reg;
    logic [VAL_W-1:0] m_value_reg;

    // Shared divider
    reav_pkg::div_stat_t div_stat;
    logic                div_start;
    logic [CNT_W-1:0]    div_quo;
    logic [CPD_W-1:0]    div_rem;
    logic [CPD_W-1:0]    cpd_eff;

    // Evaluate-stage signals
    logic             s_fire;
    logic             ch_ok_in;
    logic             is_poll;
    logic [CNT_W-1:0] raw;
    logic             moving;
    logic             dir;
    logic [CNT_W-1:0] mag;
    logic [CNT_W-1:0] acc;

    // Gain-stage signals
    logic [TIME_W-1:0]            active_new;
    logic                         dur10;
    logic [reav_pkg::GAIN_W-1:0]  gain;
    logic [STEP_W-1:0]            step_prod;

    // Update-stage signals
    logic [VAL_W-1:0] cur_val;
    logic [VAL_W:0]   up_sum;
    logic [VAL_W-1:0] down_diff;
    logic             under;
    logic [VAL_W:0]   v_raw;
    logic [VAL_W-1:0] v_new;
    logic             out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign ch_ok_in  = ({31'b0, s_channel} < 32'(CHANNELS));
    assign out_free  = !m_valid_reg || m_ready;
    assign cpd_eff   = (cpd_reg == '0) ? CPD_W'(1) : cpd_reg;

    // Decode the item against its channel state
    always_comb begin
        is_poll = (req_reg == reav_pkg::REQ_POLL) && ch_ok_reg && enabled_reg[ch_reg];
        raw     = cnt_reg - last_count_reg[ch_reg];
        moving  = is_poll && (raw != '0);
        dir     = raw[CNT_W-1];
        mag     = dir ? (~raw + CNT_W'(1)) : raw;
        acc     = mag + CNT_W'(residue_reg[ch_reg]);
    end

    assign div_start = (state_reg == S_EVAL) && moving;

    reav_div #(
        .DW(CNT_W),
        .VW(CPD_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .divisor  (cpd_eff),
        .stat     (div_stat),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // Pick the gains from detents, direction and active time
    always_comb begin
        active_new = (reversed_reg || (div_quo < reav_pkg::SLOW_DETENTS)) ? '0 : act_sum_reg;
        dur10      = !reversed_reg &&
                     !(active_new < TIME_W'(reav_pkg::period_x30(period_reg)));
        gain       = reav_pkg::gain_of(reversed_reg, div_quo, dur10);
        step_prod  = STEP_W'(div_quo) * STEP_W'(gain);
    end

    // Move the value and clamp it
    always_comb begin
        cur_val   = value_reg[ch_reg];
        up_sum    = {1'b0, cur_val} + (VAL_W + 1)'(step_reg);
        down_diff = cur_val - VAL_W'(step_reg);
        under     = {1'b0, cur_val} < (VAL_W + 1)'(step_reg);
        if (fwd_reg) begin
            v_raw = up_sum;
        end else if (under) begin
            v_raw = {1'b0, value_min_reg};
        end else begin
            v_raw = {1'b0, down_diff};
        end
        if (v_raw > {1'b0, value_max_reg}) begin
            v_new = value_max_reg;
        end else if (v_raw < {1'b0, value_min_reg}) begin
            v_new = value_min_reg;
        end else begin
            v_new = v_raw[VAL_W-1:0];
        end
    end

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg <= reav_pkg::VALUE_MIN_RST;
            value_max_reg <= reav_pkg::VALUE_MAX_RST;
            cpd_reg       <= reav_pkg::CPD_RST;
            period_reg    <= reav_pkg::PERIOD_RST;
            timeout_reg   <= reav_pkg::TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                reav_pkg::REG_VALUE_MIN: value_min_reg <= cfg_data;
                reav_pkg::REG_VALUE_MAX: value_max_reg <= cfg_data;
                reav_pkg::REG_CPD:       cpd_reg       <= cfg_data[CPD_W-1:0];
                reav_pkg::REG_PERIOD:    period_reg    <= cfg_data[reav_pkg::PER_W-1:0];
                reav_pkg::REG_TIMEOUT:   timeout_reg   <= cfg_data[reav_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence the item and update channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                enabled_reg[c]    <= 1'b0;
                last_count_reg[c] <= '0;
                turning_reg[c]    <= 1'b0;
                last_dir_reg[c]   <= 1'b0;
                residue_reg[c]    <= '0;
                active_reg[c]     <= '0;
                deadline_reg[c]   <= '0;
                value_reg[c]      <= '0;
            end
        end else begin
            // Drop the taken result unless the update stage replaces it
            if (m_valid_reg && m_ready && (state_reg != S_APPLY)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    state_reg <= S_IDLE;
                    if (ch_ok_reg) begin
                        if (req_reg == reav_pkg::REQ_START) begin
                            enabled_reg[ch_reg]    <= 1'b1;
                            last_count_reg[ch_reg] <= cnt_reg;
                        end else if (req_reg == reav_pkg::REQ_STOP) begin
                            if (enabled_reg[ch_reg]) begin
                                enabled_reg[ch_reg]    <= 1'b0;
                                last_count_reg[ch_reg] <= cnt_reg;
                            end
                        end else if (moving) begin
                            last_count_reg[ch_reg] <= cnt_reg;
                            turning_reg[ch_reg]    <= 1'b1;
                            last_dir_reg[ch_reg]   <= dir;
                            deadline_reg[ch_reg]   <= now_reg + TIME_W'(timeout_reg);
                            state_reg              <= S_DIV;
                        end else if (is_poll && turning_reg[ch_reg] &&
                                     (deadline_reg[ch_reg] < now_reg)) begin
                            // Idle too long: drop the motion state
                            turning_reg[ch_reg]    <= 1'b0;
                            last_count_reg[ch_reg] <= cnt_reg;
                            last_dir_reg[ch_reg]   <= 1'b0;
                            residue_reg[ch_reg]    <= '0;
                            active_reg[ch_reg]     <= '0;
                            deadline_reg[ch_reg]   <= '0;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    residue_reg[ch_reg] <= div_rem;
                    active_reg[ch_reg]  <= active_new;
                    state_reg           <= S_APPLY;
                end
                S_APPLY: begin
                    // Wait until the result register is free
                    if (out_free) begin
                        value_reg[ch_reg] <= v_new;
                        m_valid_reg       <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Hold the item and working values
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg    <= s_req_type;
            ch_reg     <= CH_W'(s_channel);
            ch_bit_reg <= s_channel;
            ch_ok_reg  <= ch_ok_in;
            cnt_reg    <= s_counter;
            now_reg    <= s_now_ms;
        end
        if (state_reg == S_EVAL) begin
            fwd_reg      <= !dir;
            reversed_reg <= (dir != last_dir_reg[ch_reg]);
            act_sum_reg  <= active_reg[ch_reg] + TIME_W'(period_reg);
        end
        if (state_reg == S_GAIN) begin
            step_reg <= step_prod;
        end
        if ((state_reg == S_APPLY) && out_free) begin
            m_channel_reg <= ch_bit_reg;
            m_value_reg   <= v_new;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_channel_reg;
    assign m_value       = m_value_reg;

    // The divider only runs while the sequencer waits on it
    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    // Gains are picked only on a finished division
    a_gain_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GAIN) |-> $past(div_stat.done))
        else $error("gain stage entered without a finished division");

    // A new result appears only from the update stage
    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_ready)) |-> ($past(state_reg) == S_APPLY))
        else $error("result raised outside the update stage");

    // No new item is taken while one is still in work
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input ready while an item is in work");

endmodule

`default_nettype wire

>>> rtl/reav_div.sv
// Iterative restoring divider that splits accumulated counts into detents and a residue.
`default_nettype none

module reav_div #(
    parameter int DW = reav_pkg::CNT_W,
    parameter int VW = reav_pkg::CPD_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output reav_pkg::div_stat_t stat,
    output logic      [DW-1:0] quotient,
    output logic      [VW-1:0] remainder
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;
    localparam logic [CW-1:0] LAST_BIT = CW'(DW - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] rem_next;

    // Shift in the next dividend bit and try one subtraction
    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
    end

    // Sequence one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_BIT;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the working quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> test/rotary_encoder_accelerated_value_tb.sv
// Self-checking testbench for the accelerated rotary encoder value block.
module rotary_encoder_accelerated_value_tb;

    localparam int REQ_W      = reav_pkg::REQ_W;
    localparam int CNT_W      = reav_pkg::CNT_W;
    localparam int TIME_W     = reav_pkg::TIME_W;
    localparam int VAL_W      = reav_pkg::VAL_W;
    localparam int CPD_W      = reav_pkg::CPD_W;
    localparam int PER_W      = reav_pkg::PER_W;
    localparam int TMO_W      = reav_pkg::TMO_W;
    localparam int CFG_IDX_W  = reav_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = reav_pkg::CFG_DATA_W;
    localparam int CHANNELS_DEF = reav_pkg::CHANNELS_DEF;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned SPEED_MID = 2;
    localparam int unsigned SPEED_HIGH = 10;
    localparam int unsigned DUR_GAIN = 10;
    localparam int unsigned DUR_POLLS = 30;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic              ch;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] now;
    } enc_item_t;

    typedef struct {
        logic             ch;
        logic [VAL_W-1:0] value;
    } value_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type = reav_pkg::REQ_POLL;
    logic                  s_channel = 1'b0;
    logic [CNT_W-1:0]      s_counter = '0;
    logic [TIME_W-1:0]     s_now_ms = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_out_channel;
    logic [VAL_W-1:0]      m_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = reav_pkg::REG_VALUE_MIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rotary_encoder_accelerated_value uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_channel     (s_channel),
        .s_counter     (s_counter),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_value       (m_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor copy of the registers
    logic [VAL_W-1:0] lim_min;
    logic [VAL_W-1:0] lim_max;
    logic [CPD_W-1:0] det_counts;
    logic [PER_W-1:0] period_ms;
    logic [TMO_W-1:0] timeout_ms;

    // Predictor copy of the channel state
    logic              ch_on       [CHANNELS_DEF];
    logic [CNT_W-1:0]  ch_last     [CHANNELS_DEF];
    logic              ch_turning  [CHANNELS_DEF];
    logic              ch_rev      [CHANNELS_DEF];
    logic [16:0]       ch_residue  [CHANNELS_DEF];
    logic [TIME_W-1:0] ch_active   [CHANNELS_DEF];
    logic [TIME_W-1:0] ch_deadline [CHANNELS_DEF];
    logic [VAL_W-1:0]  ch_value    [CHANNELS_DEF];

    // Stimulus-side encoder positions and clock
    logic [CNT_W-1:0]  enc_pos   [CHANNELS_DEF];
    logic              chan_live [CHANNELS_DEF];
    logic [TIME_W-1:0] clock_ms;

    enc_item_t   enc_q[$];
    value_item_t value_q[$];
    enc_item_t   next_item;
    enc_item_t   seen_item;
    value_item_t want_val;
    value_item_t got_val;

    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    logic        s_took = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Advance one channel by one item; returns 1 when the item is a moving poll, which gives a result
    function automatic bit step_channel(input enc_item_t it, output value_item_t res);
        int unsigned c;
        logic [CNT_W-1:0] raw;
        logic rev;
        int unsigned mag, cpd, acc, det, gain, stride;
        logic [31:0] v;
        c = {31'b0, it.ch};
        res.ch = it.ch;
        res.value = '0;
        if (it.req == reav_pkg::REQ_START) begin
            ch_on[c] = 1'b1;
            ch_last[c] = it.count;
            return 0;
        end
        if (it.req == reav_pkg::REQ_STOP) begin
            if (ch_on[c]) begin
                ch_on[c] = 1'b0;
                ch_last[c] = it.count;
            end
            return 0;
        end
        if (it.req != reav_pkg::REQ_POLL || !ch_on[c]) return 0;

        // Still poll: drop motion state once the deadline has passed
        raw = it.count - ch_last[c];
        if (raw == 0) begin
            if (ch_turning[c] && ch_deadline[c] < it.now) begin
                ch_turning[c] = 1'b0;
                ch_last[c] = it.count;
                ch_rev[c] = 1'b0;
                ch_residue[c] = '0;
                ch_active[c] = '0;
                ch_deadline[c] = '0;
            end
            return 0;
        end

        // Moving poll: accumulate counts into detents
        rev = raw[CNT_W-1];
        mag = rev ? (32'h10000 - 32'(raw)) : 32'(raw);
        ch_last[c] = it.count;
        ch_turning[c] = 1'b1;
        ch_active[c] = ch_active[c] + TIME_W'(period_ms);
        ch_deadline[c] = it.now + TIME_W'(timeout_ms);
        cpd = (det_counts == 0) ? 1 : 32'(det_counts);
        acc = 32'(ch_residue[c]) + mag;
        det = acc / cpd;
        ch_residue[c] = 17'(acc % cpd);

        // Gains apply only when the direction holds
        if (ch_rev[c] != rev) begin
            ch_rev[c] = rev;
            gain = 1;
            ch_active[c] = '0;
        end else begin
            if (det < reav_pkg::SLOW_DETENTS) begin
                gain = 1;
                ch_active[c] = '0;
            end else if (det < reav_pkg::FAST_DETENTS) begin
                gain = SPEED_MID;
            end else begin
                gain = SPEED_HIGH;
            end
            if (ch_active[c] >= period_ms * DUR_POLLS) gain = gain * DUR_GAIN;
        end

        // Move and saturate
        stride = det * gain;
        v = 32'(ch_value[c]);
        if (!rev) v = v + stride;
        else if (v < stride) v = 32'(lim_min);
        else v = v - stride;
        if (v > lim_max) v = 32'(lim_max);
        else if (v < lim_min) v = 32'(lim_min);
        ch_value[c] = v[VAL_W-1:0];
        res.value = ch_value[c];
        return 1;
    endfunction

    // Monitor: check results, track register writes, predict accepted items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (value_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item ch %0d value %0d",
                                            m_out_channel, m_value));
                end else begin
                    want_val = value_q.pop_front();
                    if (m_out_channel !== want_val.ch)
                        flag_mismatch($sformatf("channel %0d, want %0d",
                                                m_out_channel, want_val.ch));
                    if (m_value !== want_val.value)
                        flag_mismatch($sformatf("ch %0d value %0d, want %0d",
                                                want_val.ch, m_value, want_val.value));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    reav_pkg::REG_VALUE_MIN: lim_min = cfg_data[VAL_W-1:0];
                    reav_pkg::REG_VALUE_MAX: lim_max = cfg_data[VAL_W-1:0];
                    reav_pkg::REG_CPD:       det_counts = cfg_data[CPD_W-1:0];
                    reav_pkg::REG_PERIOD:    period_ms = cfg_data[PER_W-1:0];
                    reav_pkg::REG_TIMEOUT:   timeout_ms = cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                items_taken++;
                seen_item.req = s_req_type;
                seen_item.ch = s_channel;
                seen_item.count = s_counter;
                seen_item.now = s_now_ms;
                if (step_channel(seen_item, got_val)) value_q.push_back(got_val);
            end
        end
        s_took <= aresetn && s_valid && s_ready;
    end

    // Driver: present pending items, with random idle bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
                s_valid <= 1'b0;
                src_gap <= $urandom_range(0, 4);
            end else if (enc_q.size() != 0) begin
                next_item = enc_q.pop_front();
                s_valid <= 1'b1;
                s_req_type <= next_item.req;
                s_channel <= next_item.ch;
                s_counter <= next_item.count;
                s_now_ms <= next_item.now;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: stall in random bursts
    always @(negedge aclk) begin
        if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            m_ready <= 1'b0;
            sink_gap <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic [REQ_W-1:0] req, input logic ch,
                              input logic [CNT_W-1:0] count, input logic [TIME_W-1:0] now);
        enc_item_t it;
        it.req = req;
        it.ch = ch;
        it.count = count;
        it.now = now;
        enc_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_poll(input logic ch, input int delta);
        enc_pos[ch] = enc_pos[ch] + CNT_W'(delta);
        clock_ms = clock_ms + $urandom_range(1, 20);
        queue_item(reav_pkg::REQ_POLL, ch, enc_pos[ch], clock_ms);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every value has come, then let the block settle
    task automatic drain();
        @(negedge aclk);
        while (items_taken != items_queued || value_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed turning sessions, with stops, timeouts and noise mixed in
    task automatic queue_traffic(input int n);
        int left, kind, len, sgn, mag, cpd, pace, i;
        logic c;
        left = n;
        while (left > 0) begin
            c = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 99);
            cpd = (det_counts == 0) ? 1 : int'(det_counts);
            if (kind < 3) begin
                // unused request code
                queue_item(REQ_UNUSED, c, CNT_W'($urandom), $urandom);
            end else if (kind < 8) begin
                // stop, turn while stopped, restart at the old or a new position
                if (chan_live[c]) begin
                    clock_ms = clock_ms + $urandom_range(1, 20);
                    queue_item(reav_pkg::REQ_STOP, c, enc_pos[c], clock_ms);
                    chan_live[c] = 1'b0;
                    left--;
                    repeat ($urandom_range(0, 2)) queue_poll(c, $urandom_range(1, 300));
                    if ($urandom_range(0, 3) == 0)
                        queue_item(reav_pkg::REQ_STOP, c, CNT_W'($urandom), clock_ms);
                end
                if ($urandom_range(0, 1)) enc_pos[c] = CNT_W'($urandom);
                queue_item(reav_pkg::REQ_START, c, enc_pos[c], clock_ms);
                chan_live[c] = 1'b1;
                left--;
            end else if (kind < 14 && chan_live[c]) begin
                // still poll, past the idle timeout or not
                if ($urandom_range(0, 2) != 0)
                    clock_ms = clock_ms + TIME_W'(timeout_ms) + $urandom_range(1, 100);
                else
                    clock_ms = clock_ms + 1;
                queue_item(reav_pkg::REQ_POLL, c, enc_pos[c], clock_ms);
                left--;
            end else if (kind < 17 && chan_live[c]) begin
                // one large jump, up to half the counter range
                mag = $urandom_range(16384, 32768);
                if ($urandom_range(0, 1) && mag < 32768) queue_poll(c, mag);
                else queue_poll(c, -mag);
                left--;
            end else begin
                if (!chan_live[c]) begin
                    queue_item(reav_pkg::REQ_START, c, enc_pos[c], clock_ms);
                    chan_live[c] = 1'b1;
                    left--;
                end
                len = $urandom_range(2, 40);
                sgn = $urandom_range(0, 1) ? 1 : -1;
                pace = $urandom_range(0, 2);
                for (i = 0; i < len && left > 0; i++) begin
                    if ($urandom_range(0, 19) == 0) sgn = -sgn;
                    case (pace)
                        0: mag = $urandom_range(0, 2 * cpd);
                        1: mag = cpd * $urandom_range(5, 12) + $urandom_range(0, cpd - 1);
                        default: mag = cpd * $urandom_range(10, 40) + $urandom_range(0, cpd - 1);
                    endcase
                    if (mag > 32767) mag = 32767;
                    queue_poll(c, sgn * mag);
                    left--;
                end
            end
        end
    endtask

    task automatic run_phase(input int unsigned vmin, input int unsigned vmax,
                             input int unsigned cpd, input int unsigned per,
                             input int unsigned tmo, input logic [TIME_W-1:0] start_ms,
                             input int unsigned src_pct, input int unsigned sink_pct,
                             input int n);
        drain();
        write_reg(reav_pkg::REG_VALUE_MIN, vmin);
        write_reg(reav_pkg::REG_VALUE_MAX, vmax);
        write_reg(reav_pkg::REG_CPD, cpd);
        write_reg(reav_pkg::REG_PERIOD, per);
        write_reg(reav_pkg::REG_TIMEOUT, tmo);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        clock_ms = start_ms;
        queue_traffic(n);
    endtask

    initial begin
        lim_min = reav_pkg::VALUE_MIN_RST;
        lim_max = reav_pkg::VALUE_MAX_RST;
        det_counts = reav_pkg::CPD_RST;
        period_ms = reav_pkg::PERIOD_RST;
        timeout_ms = reav_pkg::TIMEOUT_RST;
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            ch_on[c] = 1'b0;
            ch_last[c] = '0;
            ch_turning[c] = 1'b0;
            ch_rev[c] = 1'b0;
            ch_residue[c] = '0;
            ch_active[c] = '0;
            ch_deadline[c] = '0;
            ch_value[c] = '0;
        end

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset register values
        src_idle_pct = 20;
        sink_stall_pct = 20;
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h1234, 32'd0);          // stopped channel
        queue_item(reav_pkg::REQ_STOP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);  // stop while stopped
        queue_item(REQ_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(reav_pkg::REQ_START, 1'b0, 16'h0000, 32'd0);
        queue_item(reav_pkg::REQ_START, 1'b1, 16'hFFFF, 32'd0);
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h0004, 32'd10);         // one detent forward
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h0003, 32'd20);         // reversal, residue only
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h8003, 32'd25);         // half-range reverse
        queue_item(reav_pkg::REQ_POLL, 1'b1, 16'h7FFE, 32'd30);         // largest forward step
        queue_item(reav_pkg::REQ_POLL, 1'b1, 16'h7FFE, 32'd40);         // still, before deadline
        queue_item(reav_pkg::REQ_POLL, 1'b1, 16'h7FFE, 32'd531);        // still, past deadline
        queue_item(reav_pkg::REQ_POLL, 1'b1, 16'h7FF6, 32'd540);
        queue_item(reav_pkg::REQ_START, 1'b1, 16'h0000, 32'd550);       // resync while started
        queue_item(reav_pkg::REQ_POLL, 1'b1, 16'hFFF8, 32'd560);
        queue_item(reav_pkg::REQ_STOP, 1'b0, 16'h8003, 32'd570);
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h9000, 32'd580);        // ignored while stopped
        queue_item(reav_pkg::REQ_START, 1'b0, 16'h9000, 32'd590);
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h9028, 32'hFFFF_FFF0);  // deadline wraps
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h9028, 32'hFFFF_FFFF);  // unsigned compare clears
        queue_item(reav_pkg::REQ_POLL, 1'b0, 16'h9040, 32'd0);          // medium speed gain
        queue_item(REQ_UNUSED, 1'b0, 16'h0000, 32'd0);
        queue_item(reav_pkg::REQ_STOP, 1'b1, 16'hFFF8, 32'd5);
        queue_item(reav_pkg::REQ_STOP, 1'b1, 16'hFFF8, 32'd6);
        enc_pos[0] = 16'h9040;
        enc_pos[1] = 16'hFFF8;
        chan_live[0] = 1'b1;
        chan_live[1] = 1'b0;
        clock_ms = 32'd10;

        // Random phases across register settings, extremes included
        src_idle_pct = 20;
        sink_stall_pct = 20;
        queue_traffic(150);
        run_phase(0, 24'hFFFFFF, 1, 1, 0, $urandom, 10, 30, 200);
        run_phase(1000, 5000, 255, 1000, 65535, 32'd1000, 30, 10, 150);
        run_phase(200, 50, 0, 22, 30, 32'd77, 15, 0, 150);
        run_phase(24'hFFFFFF, 24'hFFFFFF, 2, 5, 100, 32'hFFFF_FF00, 0, 25, 100);
        run_phase($urandom_range(0, 1000), $urandom_range(1000, 24'hFFFFFF),
                  $urandom_range(1, 16), $urandom_range(1, 20), $urandom_range(0, 1000),
                  $urandom, 0, 0, 350);

        drain();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
